### hw/rtl/cpt_pkg.sv
// Shared types, constants and helpers for the contact phase tracker.
package cpt_pkg;

   // Sizing of the pair tables and collider indices
   localparam int MAX_PAIRS     = 128;
   localparam int COLLIDER_BITS = 8;
   localparam int MAX_RESULTS   = 64;

   localparam int CNT_W = $clog2(MAX_PAIRS + 1);
   localparam int IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int RES_W = $clog2(MAX_RESULTS);

   // Command codes
   localparam logic [1:0] CMD_RECORD = 2'd0;
   localparam logic [1:0] CMD_END    = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   // Phase codes
   localparam logic [1:0] PHASE_ENTER = 2'd0;
   localparam logic [1:0] PHASE_STAY  = 2'd1;
   localparam logic [1:0] PHASE_EXIT  = 2'd2;
   localparam logic [1:0] PHASE_DONE  = 2'd3;

   localparam logic [31:0] ONE_F32 = 32'h3F80_0000;

   typedef logic [COLLIDER_BITS-1:0] id_type;

   typedef struct packed {
      id_type lo;
      id_type hi;
      logic   trig;
   } entry_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  collider_first;
      logic [7:0]  collider_second;
      logic        trigger_flag;
      logic [31:0] point_x;
      logic [31:0] point_y;
      logic [31:0] point_z;
      logic [31:0] normal_x;
      logic [31:0] normal_y;
      logic [31:0] normal_z;
      logic [31:0] separation_bits;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic [31:0] pair_low;
      logic [7:0]  pair_high;
      logic        trigger_out;
      logic [31:0] point_x_out;
      logic [31:0] point_y_out;
      logic [31:0] point_z_out;
      logic [31:0] normal_x_out;
      logic [31:0] normal_y_out;
      logic [31:0] normal_z_out;
      logic [31:0] separation_out;
      logic        last;
   } rsp_word_type;

   // Mask an input index byte down to the collider index width
   function automatic id_type byte_to_id(input logic [7:0] b);
      logic [15:0] wide;
      wide = {8'h00, b};
      return wide[COLLIDER_BITS-1:0];
   endfunction

   // Widen a collider index back to the byte of the result word
   function automatic logic [7:0] id_to_byte(input id_type id);
      logic [15:0] wide;
      wide = {{(16-COLLIDER_BITS){1'b0}}, id};
      return wide[7:0];
   endfunction

   // Zero-extend a collider index to a 32-bit field
   function automatic logic [31:0] id_to_word(input id_type id);
      return {{(32-COLLIDER_BITS){1'b0}}, id};
   endfunction

endpackage

### hw/rtl/cpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on enable, read every cycle into the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/contact_phase_tracker_unit.sv
// Top level of the contact phase tracker: sequencer, pair tables and result register.
//
//   channel | direction | handshake        | word
//   req_    | in        | req_valid/stall  | cpt_pkg::req_word_type
//   rsp_    | out       | rsp_valid/stall  | cpt_pkg::rsp_word_type
//
// A record word scans the current table, then the previous one; an end-of-step
// word scans the current table once for each previous-table entry. One key
// comparator steps through the table RAM read ports, one entry per cycle.
// The two tables swap roles by a bank select, so no copy. Reset clears counts and
// control only; table contents stay undefined and are never read past their fill.
// A stalled result holds the result register; the sequencer waits only to load another.
module contact_phase_tracker_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cpt_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cpt_pkg::rsp_word_type rsp_word
);
   import cpt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REC_CUR,
      ST_REC_PREV,
      ST_REC_EMIT,
      ST_END_READ,
      ST_END_LOAD,
      ST_END_SCAN,
      ST_END_EMIT,
      ST_END_DONE
   } state_type;

   state_type    state_ff, state_in;
   logic         sel_ff, sel_in;
   logic [CNT_W-1:0] cc_ff, cc_in;
   logic [CNT_W-1:0] pc_ff, pc_in;
   logic [CNT_W-1:0] rep_ff, rep_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] outer_ff, outer_in;
   logic [RES_W-1:0] nres_ff, nres_in;
   logic         pend_ff, pend_in;
   logic [31:0]  dropped_ff, dropped_in;
   entry_type    key_ff, key_in;
   logic [1:0]   phase_ff, phase_in;
   req_word_type hold_ff, hold_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic         wr_en;
   logic [IDX_W-1:0] cur_addr;
   logic [IDX_W-1:0] prev_addr;
   entry_type    ram0_q, ram1_q;
   entry_type    cur_q, prev_q, scan_q;
   logic [CNT_W-1:0] scan_cnt;
   logic         scan_hit, scan_more, scan_miss;
   logic         out_free;
   logic [31:0]  dropped_inc;
   id_type       id_a, id_b;

   // Two table banks; sel_ff names the one holding the current set
   cpt_ram #(.WIDTH($bits(entry_type)), .DEPTH(MAX_PAIRS)) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_en && !sel_ff),
      .wr_addr (cc_ff[IDX_W-1:0]),
      .wr_data (key_ff),
      .rd_addr (sel_ff ? prev_addr : cur_addr),
      .rd_data (ram0_q)
   );

   cpt_ram #(.WIDTH($bits(entry_type)), .DEPTH(MAX_PAIRS)) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_en && sel_ff),
      .wr_addr (cc_ff[IDX_W-1:0]),
      .wr_data (key_ff),
      .rd_addr (sel_ff ? cur_addr : prev_addr),
      .rd_data (ram1_q)
   );

   assign cur_q  = sel_ff ? ram1_q : ram0_q;
   assign prev_q = sel_ff ? ram0_q : ram1_q;

   // Shared key compare against whichever bank the scan walks
   always_comb begin
      scan_q   = (state_ff == ST_REC_PREV) ? prev_q : cur_q;
      scan_cnt = (state_ff == ST_REC_PREV) ? pc_ff : cc_ff;
      scan_hit  = pend_ff && (scan_q.lo == key_ff.lo) && (scan_q.hi == key_ff.hi);
      scan_more = idx_ff < scan_cnt;
      scan_miss = !scan_hit && !scan_more;
   end

   assign cur_addr  = idx_ff[IDX_W-1:0];
   assign prev_addr = (state_ff == ST_END_READ) ? outer_ff[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign dropped_inc = (dropped_ff == 32'hFFFF_FFFF) ? dropped_ff : dropped_ff + 32'd1;
   assign id_a = byte_to_id(req_word.collider_first);
   assign id_b = byte_to_id(req_word.collider_second);

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      cc_in        = cc_ff;
      pc_in        = pc_ff;
      rep_in       = rep_ff;
      idx_in       = idx_ff;
      outer_in     = outer_ff;
      nres_in      = nres_ff;
      pend_in      = pend_ff;
      dropped_in   = dropped_ff;
      key_in       = key_ff;
      phase_in     = phase_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      wr_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               hold_in = req_word;
               idx_in  = '0;
               pend_in = 1'b0;
               case (req_word.command)
                  CMD_RECORD: begin
                     key_in.lo   = (id_a < id_b) ? id_a : id_b;
                     key_in.hi   = (id_a < id_b) ? id_b : id_a;
                     key_in.trig = req_word.trigger_flag;
                     state_in    = ST_REC_CUR;
                  end
                  CMD_END: begin
                     outer_in = '0;
                     nres_in  = '0;
                     state_in = ST_END_READ;
                  end
                  CMD_CLEAR: begin
                     cc_in  = '0;
                     pc_in  = '0;
                     rep_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Drop the record if the pair is already in this step's set
         ST_REC_CUR: begin
            if (scan_hit) begin
               state_in = ST_IDLE;
            end else if (scan_more) begin
               idx_in  = idx_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               if (cc_ff < CNT_W'(MAX_PAIRS)) begin
                  wr_en = 1'b1;
                  cc_in = cc_ff + 1'b1;
               end
               idx_in   = '0;
               pend_in  = 1'b0;
               state_in = ST_REC_PREV;
            end
         end

         // Look the pair up in the previous set to pick enter or stay, or drop it when the result count is full
         ST_REC_PREV: begin
            if (scan_hit || scan_miss) begin
               phase_in = scan_hit ? PHASE_STAY : PHASE_ENTER;
               if (rep_ff >= CNT_W'(MAX_PAIRS)) begin
                  dropped_in = dropped_inc;
                  state_in   = ST_IDLE;
               end else begin
                  state_in = ST_REC_EMIT;
               end
            end else begin
               idx_in  = idx_ff + 1'b1;
               pend_in = 1'b1;
            end
         end

         ST_REC_EMIT: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_word_in.phase          = phase_ff;
               rsp_word_in.pair_low       = id_to_word(key_ff.lo);
               rsp_word_in.pair_high      = id_to_byte(key_ff.hi);
               rsp_word_in.trigger_out    = key_ff.trig;
               rsp_word_in.point_x_out    = hold_ff.point_x;
               rsp_word_in.point_y_out    = hold_ff.point_y;
               rsp_word_in.point_z_out    = hold_ff.point_z;
               rsp_word_in.normal_x_out   = hold_ff.normal_x;
               rsp_word_in.normal_y_out   = hold_ff.normal_y;
               rsp_word_in.normal_z_out   = hold_ff.normal_z;
               rsp_word_in.separation_out = hold_ff.separation_bits;
               rsp_word_in.last           = 1'b1;
               rep_in                     = rep_ff + 1'b1;
               state_in                   = ST_IDLE;
            end
         end

         // Fetch the next previous-set entry, or finish the step
         ST_END_READ: begin
            state_in = (outer_ff < pc_ff) ? ST_END_LOAD : ST_END_DONE;
         end

         ST_END_LOAD: begin
            key_in   = prev_q;
            idx_in   = '0;
            pend_in  = 1'b0;
            state_in = ST_END_SCAN;
         end

         // Report an exit for a previous pair missing from the current set, or drop it when result limits are reached
         ST_END_SCAN: begin
            if (scan_hit) begin
               outer_in = outer_ff + 1'b1;
               state_in = ST_END_READ;
            end else if (scan_more) begin
               idx_in  = idx_ff + 1'b1;
               pend_in = 1'b1;
            end else if (rep_ff >= CNT_W'(MAX_PAIRS) ||
                         nres_ff >= RES_W'(MAX_RESULTS - 1)) begin
               dropped_in = dropped_inc;
               outer_in   = outer_ff + 1'b1;
               state_in   = ST_END_READ;
            end else begin
               state_in = ST_END_EMIT;
            end
         end

         ST_END_EMIT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_word_in               = '0;
               rsp_word_in.phase         = PHASE_EXIT;
               rsp_word_in.pair_low      = id_to_word(key_ff.lo);
               rsp_word_in.pair_high     = id_to_byte(key_ff.hi);
               rsp_word_in.trigger_out   = key_ff.trig;
               rsp_word_in.normal_y_out  = ONE_F32;
               rep_in                    = rep_ff + 1'b1;
               nres_in                   = nres_ff + 1'b1;
               outer_in                  = outer_ff + 1'b1;
               state_in                  = ST_END_READ;
            end
         end

         // Emit the done marker and swap the banks
         ST_END_DONE: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_word_in          = '0;
               rsp_word_in.phase    = PHASE_DONE;
               rsp_word_in.pair_low = dropped_ff;
               rsp_word_in.last     = 1'b1;
               sel_in               = !sel_ff;
               pc_in                = cc_ff;
               cc_in                = '0;
               rep_in               = '0;
               state_in             = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= 1'b0;
         cc_ff        <= '0;
         pc_ff        <= '0;
         rep_ff       <= '0;
         idx_ff       <= '0;
         outer_ff     <= '0;
         nres_ff      <= '0;
         pend_ff      <= 1'b0;
         dropped_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         cc_ff        <= cc_in;
         pc_ff        <= pc_in;
         rep_ff       <= rep_in;
         idx_ff       <= idx_in;
         outer_ff     <= outer_in;
         nres_ff      <= nres_in;
         pend_ff      <= pend_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      phase_ff    <= phase_in;
      hold_ff     <= hold_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
